@@ src/pli_pkg.sv @@
`timescale 1ns / 1ps
// pli_pkg: types, codes and constants shared by the positional list files
// no dependencies

package pli_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int COUNT_OUT_W  = 6;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [2:0] {
    ACT_APPEND     = 3'd0,
    ACT_INS_HEAD   = 3'd1,
    ACT_INS_POS    = 3'd2,
    ACT_DEL_POS    = 3'd3,
    ACT_DUMP       = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_kind_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } pli_state_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    action_t                  action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     last;
  } rsp_t;

endpackage

@@ src/pli_cell.sv @@
`timescale 1ns / 1ps
// pli_cell: one storage cell of the list, takes its neighbour's word on shifts
// depends on pli_pkg

module pli_cell #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0
) (
  input  logic                              clk,
  input  pli_pkg::cell_ctl_t                ctl,
  input  logic [$clog2(CAPACITY)-1:0]       idx,
  input  logic [$clog2(CAPACITY+1)-1:0]     cnt,
  input  logic signed [pli_pkg::DATA_W-1:0] left,
  input  logic signed [pli_pkg::DATA_W-1:0] right,
  input  logic signed [pli_pkg::DATA_W-1:0] head,
  output logic signed [pli_pkg::DATA_W-1:0] q,
  output logic signed [pli_pkg::DATA_W-1:0] tail_tap,
  output logic signed [pli_pkg::DATA_W-1:0] pre_tap
);
  import pli_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
  localparam logic [CNT_W:0]   TAIL_CNT = (CNT_W + 1)'(INDEX + 1);
  localparam logic [CNT_W:0]   PRE_CNT  = (CNT_W + 1)'(INDEX + 2);

  logic [CNT_W:0]           cnt_x;
  logic                     is_tail;
  logic                     is_pre;
  logic signed [DATA_W-1:0] q_next;

  assign cnt_x    = {1'b0, cnt};
  assign is_tail  = (cnt_x == TAIL_CNT);
  assign is_pre   = (cnt_x == PRE_CNT);
  assign tail_tap = is_tail ? q : '0;
  assign pre_tap  = is_pre ? q : '0;

  always_comb begin
    q_next = q;
    case (ctl.kind)
      CMD_INSERT: begin
        if (MY_IDX == idx) begin
          q_next = ctl.value;
        end else if (MY_IDX > idx) begin
          q_next = left;
        end
      end
      CMD_DELETE: begin
        if (MY_IDX >= idx) begin
          q_next = right;
        end
      end
      CMD_ROTATE: begin
        q_next = is_tail ? head : right;
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

@@ src/pli_chain.sv @@
`timescale 1ns / 1ps
// pli_chain: row of list cells with head, tail and pre-tail taps
// depends on pli_pkg and pli_cell

module pli_chain #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  pli_pkg::cell_ctl_t                ctl,
  input  logic [$clog2(CAPACITY)-1:0]       idx,
  input  logic [$clog2(CAPACITY+1)-1:0]     cnt,
  output logic signed [pli_pkg::DATA_W-1:0] first,
  output logic signed [pli_pkg::DATA_W-1:0] second,
  output logic signed [pli_pkg::DATA_W-1:0] tail,
  output logic signed [pli_pkg::DATA_W-1:0] pre_tail
);
  import pli_pkg::*;

  logic signed [DATA_W-1:0] cell_q    [CAPACITY];
  logic signed [DATA_W-1:0] tail_taps [CAPACITY];
  logic signed [DATA_W-1:0] pre_taps  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[g+1];
    end

    pli_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (idx),
      .cnt      (cnt),
      .left     (left_d),
      .right    (right_d),
      .head     (cell_q[0]),
      .q        (cell_q[g]),
      .tail_tap (tail_taps[g]),
      .pre_tap  (pre_taps[g])
    );
  end

  assign first  = cell_q[0];
  assign second = cell_q[1];

  always_comb begin
    tail     = '0;
    pre_tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail     = tail | tail_taps[i];
      pre_tail = pre_tail | pre_taps[i];
    end
  end

endmodule

@@ src/positional_list_insert_delete.sv @@
`timescale 1ns / 1ps
// positional_list_insert_delete: ordered list of signed words held in a row of shift cells
// depends on pli_pkg and pli_chain
//
// Each request transaction (append, insert at head, insert at position, delete at
// position) is applied to the cell row in the cycle it is accepted and gives one
// response in the following cycle, so these run at one per cycle while the response
// side keeps up. A dump of n entries snapshots the head and tail in the accepting
// cycle, then the row rotates once per response, giving n responses at one per cycle
// while the response side keeps up, during which req_stall is held high; an empty dump
// gives one response like any other request. The response register is the limit: one
// response transaction per cycle, and a stalled response holds off the request side.

module positional_list_insert_delete #(
  parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pli_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pli_pkg::rsp_t rsp
);
  import pli_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  pli_state_t               state;
  pli_state_t               state_next;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [IDX_W-1:0]         dump_cnt;
  logic [IDX_W-1:0]         dump_cnt_next;
  logic signed [DATA_W-1:0] dump_head;
  logic signed [DATA_W-1:0] dump_tail;
  logic                     dump_snap;

  cell_ctl_t                ctl;
  logic [IDX_W-1:0]         idx;
  logic signed [DATA_W-1:0] first;
  logic signed [DATA_W-1:0] second;
  logic signed [DATA_W-1:0] tail;
  logic signed [DATA_W-1:0] pre_tail;

  logic                     out_free;
  logic                     accept;
  logic                     rsp_load;
  rsp_t                     rsp_next;

  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;
  logic [CNT_W-1:0]         cnt_m1;
  logic [IDX_W-1:0]         pos_idx;
  logic                     is_empty;
  logic                     is_full;

  pli_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .idx      (idx),
    .cnt      (cnt),
    .first    (first),
    .second   (second),
    .tail     (tail),
    .pre_tail (pre_tail)
  );

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state == S_DUMP) || !out_free;
  assign accept    = req_valid && !req_stall;

  assign pos_x    = CMP_W'(req.position);
  assign cnt_x    = CMP_W'(cnt);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign pos_idx  = IDX_W'(req.position - POS_W'(1));
  assign is_empty = (cnt == '0);
  assign is_full  = (cnt == CNT_FULL);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    dump_cnt_next = dump_cnt;
    dump_snap     = 1'b0;
    ctl.kind      = CMD_HOLD;
    ctl.value     = req.value_in;
    idx           = '0;
    rsp_load      = 1'b0;

    rsp_next.status      = ST_OK;
    rsp_next.item_value  = '0;
    rsp_next.head_value  = is_empty ? '0 : first;
    rsp_next.tail_value  = tail;
    rsp_next.entry_count = COUNT_OUT_W'(cnt);
    rsp_next.last        = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (req.action)
            ACT_APPEND, ACT_INS_HEAD, ACT_INS_POS: begin
              if (req.action == ACT_APPEND) begin
                idx = IDX_W'(cnt);
              end else if (req.action == ACT_INS_HEAD) begin
                idx = '0;
              end else begin
                idx = pos_idx;
              end
              if (req.action == ACT_INS_POS && is_empty) begin
                rsp_next.status = ST_EMPTY;
              end else if (req.action == ACT_INS_POS &&
                           (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
                rsp_next.status = ST_BADPOS;
              end else if (is_full) begin
                rsp_next.status = ST_FULL;
              end else begin
                ctl.kind                 = CMD_INSERT;
                cnt_next                 = cnt + CNT_W'(1);
                rsp_next.entry_count     = COUNT_OUT_W'(cnt_next);
                rsp_next.head_value      = (idx == '0) ? req.value_in : first;
                rsp_next.tail_value      = (CNT_W'(idx) == cnt) ? req.value_in : tail;
              end
            end
            ACT_DEL_POS: begin
              idx = pos_idx;
              if (is_empty) begin
                rsp_next.status = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                rsp_next.status = ST_BADPOS;
              end else begin
                ctl.kind             = CMD_DELETE;
                cnt_next             = cnt_m1;
                rsp_next.entry_count = COUNT_OUT_W'(cnt_next);
                if (cnt_next == '0) begin
                  rsp_next.head_value = '0;
                  rsp_next.tail_value = '0;
                end else begin
                  rsp_next.head_value = (idx == '0) ? second : first;
                  rsp_next.tail_value = (CNT_W'(idx) == cnt_m1) ? pre_tail : tail;
                end
              end
            end
            ACT_DUMP: begin
              if (is_empty) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                rsp_load      = 1'b0;
                dump_snap     = 1'b1;
                dump_cnt_next = '0;
                state_next    = S_DUMP;
              end
            end
            default: begin
              rsp_next.status = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        rsp_next.head_value = dump_head;
        rsp_next.tail_value = dump_tail;
        rsp_next.item_value = first;
        rsp_next.last       = (CNT_W'(dump_cnt) == cnt_m1);
        if (out_free) begin
          rsp_load      = 1'b1;
          ctl.kind      = CMD_ROTATE;
          dump_cnt_next = dump_cnt + IDX_W'(1);
          if (rsp_next.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      dump_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      dump_cnt <= dump_cnt_next;
      if (out_free) begin
        rsp_valid <= rsp_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    if (dump_snap) begin
      dump_head <= first;
      dump_tail <= tail;
    end
  end

endmodule
